FILE: rtl/fhuac_pkg.sv
// shared constants and helpers for the framed hex uid access check
`timescale 1ns / 1ps

package fhuac_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // framing bytes
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;

    // hex parse phases
    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_ZERO   = 3'd1;
    localparam logic [2:0] PH_PREFIX = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_digit_t;

    // ascii hex character to nibble
    function automatic hex_digit_t fhuac_hex(input logic [7:0] c);
        hex_digit_t r;
        r.ok  = 1'b1;
        r.nib = 4'd0;
        case (c) inside
            [8'h30:8'h39]: r.nib = c[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: r.nib = c[3:0] + 4'd9;
            default:       r.ok  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/framed_hex_uid_access_check.sv
// framed hex card identifier parser with allow-list lookup
`timescale 1ns / 1ps

// usage
// - slave channel: one beat per item; tuser selects the kind (serial byte,
//   append allow-list entry, clear allow-list), tdata carries the byte and
//   the entry value
// - master channel: one beat per frame closed by etx, carrying the parsed
//   identifier shifted right by one and the granted flag
// - serial bytes other than a closing etx, appends and clears leave the block
//   ready for the next item
// - a closing etx starts a linear search of the allow-list through the one
//   read port of the table ram: one entry per cycle, ending after the last
//   entry on a miss and earlier on a hit; an identifier of 2^32 or more
//   skips the search
// - the result sits in an output register, so bytes keep flowing while it
//   waits; only a further etx result waits for the register to drain
// - a receiver stall holds the result beat stable until it is taken
// - reset clears the frame state, the parser and the entry count; the
//   table contents are left as they are and only entries below the entry
//   count are ever read, so no clearing pass is needed

module framed_hex_uid_access_check #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAME_LIMIT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte[7:0], entry_value[39:8]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // card_uid[62:0], granted[63]
);

    import fhuac_pkg::*;

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int FLW = $clog2(FRAME_LIMIT);
    localparam logic [CW-1:0]  COUNT_FULL = CW'(TABLE_DEPTH);
    localparam logic [FLW-1:0] FLEN_MAX   = FLW'(FRAME_LIMIT - 2);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic           in_frame_reg, in_frame_next;
    logic [2:0]     phase_reg, phase_next;
    logic [63:0]    acc_reg, acc_next;
    logic           ovf_reg, ovf_next;
    logic [FLW-1:0] flen_reg, flen_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           pend_reg, pend_next;
    logic           grant_reg, grant_next;
    logic [62:0]    uid_reg, uid_next;
    logic           m_valid_reg, m_valid_next;
    logic [63:0]    m_data_reg, m_data_next;

    logic [1:0]     in_op;
    logic [7:0]     in_byte;
    logic [31:0]    in_entry;
    logic           s_fire;
    hex_digit_t     hex;
    logic           take_dig;
    logic [63:0]    final_val;

    logic           ram_we;
    logic           ram_re;
    logic [31:0]    ram_rdata;

    assign in_op    = s_axis_tuser;
    assign in_byte  = s_axis_tdata[7:0];
    assign in_entry = s_axis_tdata[39:8];

    // items are taken only while idle: not during a search or while a result waits to load
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign hex       = fhuac_hex(in_byte);
    assign final_val = ovf_reg ? {64{1'b1}} : acc_reg;

    assign ram_we = s_fire && (in_op == OP_APPEND) && (count_reg != COUNT_FULL);
    assign ram_re = (state_reg == ST_SEARCH);

    fhuac_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_entry),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        in_frame_next = in_frame_reg;
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        flen_next     = flen_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        grant_next    = grant_reg;
        uid_next      = uid_reg;
        take_dig      = 1'b0;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (in_op)
                        OP_APPEND: begin
                            if (count_reg != COUNT_FULL) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_BYTE: begin
                            if (in_byte == BYTE_STX) begin
                                // open or restart a frame
                                in_frame_next = 1'b1;
                                phase_next    = PH_SPACE;
                                acc_next      = '0;
                                ovf_next      = 1'b0;
                                flen_next     = '0;
                            end else if (in_frame_reg) begin
                                if (in_byte == BYTE_ETX) begin
                                    in_frame_next = 1'b0;
                                    uid_next      = final_val[63:1];
                                    grant_next    = 1'b0;
                                    idx_next      = '0;
                                    // wide identifiers never match a 32-bit entry
                                    if (final_val[63:33] != '0) begin
                                        state_next = ST_DONE;
                                    end else begin
                                        state_next = ST_SEARCH;
                                    end
                                end else if (flen_reg >= FLEN_MAX) begin
                                    // frame too long, drop it
                                    in_frame_next = 1'b0;
                                end else begin
                                    flen_next = flen_reg + 1'b1;
                                    if (in_byte != BYTE_CR && in_byte != BYTE_LF) begin
                                        case (phase_reg)
                                            PH_SPACE: begin
                                                if (in_byte == 8'h20 ||
                                                    in_byte inside {[8'h09:8'h0D]}) begin
                                                    phase_next = PH_SPACE;
                                                end else if (in_byte == 8'h30) begin
                                                    phase_next = PH_ZERO;
                                                end else if (hex.ok) begin
                                                    take_dig   = 1'b1;
                                                    phase_next = PH_DIGITS;
                                                end else begin
                                                    phase_next = PH_DONE;
                                                end
                                            end
                                            PH_ZERO: begin
                                                if (in_byte == 8'h78 || in_byte == 8'h58) begin
                                                    phase_next = PH_PREFIX;
                                                end else if (hex.ok) begin
                                                    take_dig   = 1'b1;
                                                    phase_next = PH_DIGITS;
                                                end else begin
                                                    phase_next = PH_DONE;
                                                end
                                            end
                                            PH_PREFIX,
                                            PH_DIGITS: begin
                                                if (hex.ok) begin
                                                    take_dig   = 1'b1;
                                                    phase_next = PH_DIGITS;
                                                end else begin
                                                    phase_next = PH_DONE;
                                                end
                                            end
                                            default: begin
                                                phase_next = PH_DONE;
                                            end
                                        endcase
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // compare last cycle's read, else issue the next address
                if (pend_reg && ram_rdata == uid_reg[31:0]) begin
                    grant_next = 1'b1;
                    state_next = ST_DONE;
                end else if (idx_reg == count_reg) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end
            ST_DONE: begin
                // load the output register once it is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {grant_reg, uid_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // digit accumulate with saturation on overflow
        if (take_dig && !ovf_reg) begin
            if (acc_reg[63:60] != 4'd0) begin
                ovf_next = 1'b1;
            end else begin
                acc_next = {acc_reg[59:0], hex.nib};
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_frame_reg <= 1'b0;
            phase_reg    <= PH_SPACE;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            flen_reg     <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_frame_reg <= in_frame_next;
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
            flen_reg     <= flen_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        grant_reg  <= grant_next;
        uid_reg    <= uid_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    // entry count never runs past the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_FULL)
        else $error("entry count beyond table depth");

    // search index stays within the loaded entries
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (idx_reg <= count_reg))
        else $error("search index past entry count");

    // a closing etx always leaves idle for the lookup
    a_etx_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_op == OP_BYTE && in_byte == BYTE_ETX && in_frame_reg)
        |=> (state_reg != ST_IDLE))
        else $error("etx did not start a lookup");

    // frame length stays under the limit
    a_flen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        flen_reg <= FLEN_MAX)
        else $error("frame length past limit");

    // a result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_axis_tready)
        |=> (state_reg == ST_DONE))
        else $error("result loaded over a pending beat");
`endif

endmodule

FILE: rtl/fhuac_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module fhuac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: tb/fhuac_access_checker.sv
// checker for the framed hex uid access check: tracks both channels and compares results
`timescale 1ns / 1ps

module fhuac_access_checker #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAME_LIMIT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte[7:0], entry_value[39:8]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // card_uid[62:0], granted[63]
    output int          fail_count,
    output int          results_owed
);
    import fhuac_pkg::*;

    typedef struct packed {
        logic [62:0] card_uid;
        logic        granted;
    } card_result_t;

    card_result_t expected_grants[$];

    // shadow of the reader state
    logic        in_frame;
    logic [2:0]  phase;
    logic [63:0] acc;
    logic        saturated;
    int          frame_len;
    logic [31:0] allow_ids [TABLE_DEPTH];
    int          loaded;
    int          mismatches = 0;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        return -1;
    endfunction

    function automatic logic on_allow_list(input logic [62:0] uid);
        if (uid > 63'hFFFF_FFFF) return 1'b0;
        for (int i = 0; i < loaded; i++)
            if (allow_ids[i] == uid[31:0]) return 1'b1;
        return 1'b0;
    endfunction

    task automatic shift_in_digit(input int d);
        if (saturated) return;
        if (acc > 64'h0FFF_FFFF_FFFF_FFFF)
            saturated = 1'b1;
        else
            acc = {acc[59:0], 4'(d)};
    endtask

    task automatic parse_char(input logic [7:0] c);
        int d;
        d = nibble_of(c);
        case (phase)
            PH_SPACE: begin
                if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
                    phase = PH_SPACE;
                else if (c == 8'h30)
                    phase = PH_ZERO;
                else if (d >= 0) begin
                    shift_in_digit(d);
                    phase = PH_DIGITS;
                end else
                    phase = PH_DONE;
            end
            PH_ZERO: begin
                if (c == 8'h78 || c == 8'h58)
                    phase = PH_PREFIX;
                else if (d >= 0) begin
                    shift_in_digit(d);
                    phase = PH_DIGITS;
                end else
                    phase = PH_DONE;
            end
            PH_PREFIX, PH_DIGITS: begin
                if (d >= 0) begin
                    shift_in_digit(d);
                    phase = PH_DIGITS;
                end else
                    phase = PH_DONE;
            end
            default: phase = PH_DONE;
        endcase
    endtask

    task automatic predict_access(input logic [1:0] op, input logic [7:0] c,
                                  input logic [31:0] ev);
        card_result_t r;
        logic [63:0]  v;
        case (op)
            OP_APPEND: begin
                if (loaded < TABLE_DEPTH) begin
                    allow_ids[loaded] = ev;
                    loaded++;
                end
            end
            OP_CLEAR: loaded = 0;
            OP_BYTE: begin
                if (c == BYTE_STX) begin
                    in_frame  = 1'b1;
                    phase     = PH_SPACE;
                    acc       = '0;
                    saturated = 1'b0;
                    frame_len = 0;
                end else if (in_frame) begin
                    if (c == BYTE_ETX) begin
                        v          = saturated ? '1 : acc;
                        r.card_uid = v[63:1];
                        r.granted  = on_allow_list(r.card_uid);
                        in_frame   = 1'b0;
                        expected_grants.push_back(r);
                    end else if (frame_len >= FRAME_LIMIT - 2) begin
                        in_frame = 1'b0;
                    end else begin
                        frame_len++;
                        if (c != BYTE_CR && c != BYTE_LF) parse_char(c);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input logic [63:0] beat);
        card_result_t want;
        if (expected_grants.size() == 0) begin
            $error("result beat with nothing expected: card_uid %h granted %b",
                   beat[62:0], beat[63]);
            mismatches++;
        end else begin
            want = expected_grants.pop_front();
            if (beat[62:0] !== want.card_uid) begin
                $error("card_uid mismatch: expected %h, got %h", want.card_uid, beat[62:0]);
                mismatches++;
            end
            if (beat[63] !== want.granted) begin
                $error("granted mismatch: expected %b, got %b", want.granted, beat[63]);
                mismatches++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_frame  = 1'b0;
            phase     = PH_SPACE;
            acc       = '0;
            saturated = 1'b0;
            frame_len = 0;
            loaded    = 0;
            expected_grants.delete();
        end else begin
            // a result can never come from the beat taken at the same edge
            if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                predict_access(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8]);
        end
        results_owed <= expected_grants.size();
        fail_count   <= mismatches;
    end

endmodule

FILE: tb/framed_hex_uid_access_check_tb.sv
// testbench top for the framed hex uid access check: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module framed_hex_uid_access_check_tb;
    import fhuac_pkg::*;

    localparam int TABLE_DEPTH    = 1024;
    localparam int FRAME_LIMIT    = 256;
    localparam int RANDOM_ITEMS   = 400;
    // longest quiet stretch: a full-table search plus a long receiver stall
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 32;

    // the one item kind the block does not define
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;     // data_byte[7:0], entry_value[39:8]
    logic [1:0]  s_axis_tuser  = OP_BYTE; // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // card_uid[62:0], granted[63]

    int fail_count;
    int results_owed;

    // sender bookkeeping
    int          burst_left    = 0;
    int          stim_items    = 0;
    int          ignored_items = 0;
    logic [31:0] loaded_ids[$];

    // receiver stall pattern
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  stall_phase   = '0;
    int          stall_timer   = 0;

    int quiet_cycles = 0;

    // white space the parser skips, cr and lf among them
    logic [7:0] blank_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    framed_hex_uid_access_check #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAME_LIMIT (FRAME_LIMIT)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fhuac_access_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAME_LIMIT (FRAME_LIMIT)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .results_owed  (results_owed)
    );

    always #4 aclk = ~aclk;

    // receiver: a 16-bit ready pattern, stepped through bit by bit and re-drawn when the timer runs out;
    // all-ones patterns give stretches with no stall at all
    always @(posedge aclk) begin
        if (stall_timer == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pattern <= 16'hFFFF;
                1:       stall_pattern <= 16'($urandom()) | 16'h0001;
                2:       stall_pattern <= (16'($urandom()) & 16'($urandom())) | 16'h0001;
                default: stall_pattern <= 16'($urandom()) | 16'($urandom()) | 16'h0001;
            endcase
            stall_timer <= 63;
        end else begin
            stall_timer <= stall_timer - 1;
        end
        m_axis_tready <= stall_pattern[stall_phase];
        stall_phase   <= stall_phase + 4'd1;
    end

    // watchdog: no beat on either channel for too long ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        // letters in either case
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // one beat on the slave channel; bursts of random length with random gaps
    task automatic put_item(input logic [1:0] op, input logic [7:0] b, input logic [31:0] ev);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {ev, b};
        do @(posedge aclk); while (!s_axis_tready);
        stim_items++;
    endtask

    // unused fields carry random bits so every input bit toggles
    task automatic put_byte(input logic [7:0] b);
        put_item(OP_BYTE, b, $urandom());
    endtask

    task automatic put_append(input logic [31:0] ev);
        if (loaded_ids.size() < TABLE_DEPTH) loaded_ids.push_back(ev);
        put_item(OP_APPEND, 8'($urandom_range(0, 255)), ev);
    endtask

    task automatic put_clear();
        loaded_ids.delete();
        put_item(OP_CLEAR, 8'($urandom_range(0, 255)), $urandom());
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_frame(input string s);
        put_byte(BYTE_STX);
        put_text(s);
        put_byte(BYTE_ETX);
    endtask

    // hex digits of v, with an optional 0x prefix or one or two leading zeros
    task automatic put_number(input logic [63:0] v);
        int nib_count;
        int pick;
        nib_count = 1;
        for (int k = 0; k < 16; k++)
            if (v[k*4 +: 4] != 4'd0) nib_count = k + 1;
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
            put_byte(8'h30);
            put_byte($urandom_range(0, 1) ? 8'h78 : 8'h58);
        end else if (pick == 1) begin
            repeat ($urandom_range(1, 2)) put_byte(8'h30);
        end
        for (int k = nib_count - 1; k >= 0; k--) put_byte(hex_char(v[k*4 +: 4]));
    endtask

    task automatic put_uid_frame(input logic [62:0] uid);
        put_byte(BYTE_STX);
        put_number({uid, 1'($urandom_range(0, 1))});
        put_byte(BYTE_ETX);
    endtask

    // mostly well-formed frames with random content; some overflow,
    // some garbage, some trailing junk and a few left open
    task automatic put_random_frame();
        logic [63:0] v;
        int          mode;
        put_byte(BYTE_STX);
        repeat ($urandom_range(0, 2)) put_byte(blank_chars[$urandom_range(0, 5)]);
        mode = $urandom_range(0, 9);
        if (mode < 4 && loaded_ids.size() > 0) begin
            // aim at a loaded entry so grants are common
            v = {31'd0, loaded_ids[$urandom_range(0, loaded_ids.size() - 1)],
                 1'($urandom_range(0, 1))};
            put_number(v);
        end else if (mode < 6) begin
            v = 64'($urandom()) >> $urandom_range(0, 31);
            put_number(v);
        end else if (mode < 8) begin
            v = {$urandom(), $urandom()};
            put_number(v);
        end else if (mode == 8) begin
            // more digits than 64 bits hold: saturates
            put_byte(hex_char(4'($urandom_range(1, 15))));
            repeat ($urandom_range(16, 19)) put_byte(hex_char(4'($urandom_range(0, 15))));
        end else begin
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) < 3)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) != 0) put_byte(BYTE_ETX);
    endtask

    // content_len bytes of white space and "2468z" between stx and etx
    task automatic put_padded_frame(input int content_len);
        put_byte(BYTE_STX);
        repeat (content_len - 5) put_byte(blank_chars[$urandom_range(0, 5)]);
        put_text("2468z");
        put_byte(BYTE_ETX);
    endtask

    // sender pause until every outstanding result has been taken
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        burst_left = 0;
    endtask

    initial begin
        int random_start;
        int choice;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        put_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);   // unknown op does nothing
        put_append(32'h0000_1234);
        put_append(32'hFFFF_FFFF);
        put_append(32'h0000_0000);
        put_byte(8'h41);                             // outside a frame: ignored
        put_byte(BYTE_ETX);                          // stray etx: no result
        // second stx restarts, cr dropped, leading space skipped: granted 0x1234
        put_byte(BYTE_STX);
        put_byte(8'h37);
        put_byte(BYTE_STX);
        put_byte(BYTE_CR);
        put_text(" 2468");
        put_byte(BYTE_ETX);
        put_frame("0x");                             // prefix without digits gives zero
        put_frame("+5");                             // sign character ends the number
        put_frame("");                               // empty content
        put_frame("1FFFFFFFE");                      // largest entry value
        put_frame("fffffffffffffffff");              // saturates, uid all ones
        put_frame("0X3");
        put_clear();
        put_frame("2468");                           // list cleared: no grant

        // ---- random part ----
        random_start = stim_items;
        while (stim_items - ignored_items - random_start < RANDOM_ITEMS) begin
            choice = $urandom_range(0, 99);
            if (choice < 60) begin
                put_random_frame();
            end else if (choice < 75) begin
                if (loaded_ids.size() > 48) begin
                    put_clear();
                end else begin
                    repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(0, 2))
                            0:       put_append($urandom());
                            1:       put_append($urandom_range(0, 255));
                            default: put_append(32'hFFFF_FFFF);
                        endcase
                    end
                end
            end else if (choice < 78) begin
                put_clear();
            end else if (choice < 83) begin
                put_item(OP_UNUSED, 8'($urandom_range(0, 255)), $urandom());
            end else if (choice < 93) begin
                put_byte(8'($urandom_range(0, 255)));
                ignored_items++;
            end else if (choice < 97) begin
                hold_until_drained();
            end else begin
                // short frame of raw noise
                put_byte(BYTE_STX);
                repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
                put_byte(BYTE_ETX);
            end
        end

        // ---- frame length limit ----
        hold_until_drained();
        put_append(32'h0000_1234);
        put_padded_frame(FRAME_LIMIT - 2);           // longest frame that still gives a result
        put_padded_frame(FRAME_LIMIT - 1);           // one byte too many: discarded
        put_text("13");
        put_byte(BYTE_ETX);                          // frame already dropped: ignored
        put_frame("2468");

        // ---- full allow-list ----
        hold_until_drained();
        put_clear();
        for (int i = 0; i < TABLE_DEPTH; i++) put_append(32'h8000_0000 | i);
        put_append(32'h4000_0000);                   // list full: ignored
        put_uid_frame(63'h8000_0000);
        put_uid_frame(63'(32'h8000_0000 | (TABLE_DEPTH - 1)));
        put_uid_frame(63'h4000_0000);
        put_uid_frame(63'h1_0000_0000);              // wide identifier never matches
        put_clear();
        put_random_frame();

        // ---- drain and verdict ----
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && results_owed == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
